// ===== src/wdv_pkg.sv =====
// wdv_pkg: shared types and constants for the word divider
`timescale 1ns / 1ps

package wdv_pkg;

    // quotient bits produced by the restoring divide
    localparam int QUOT_BITS = 16;
    // restoring steps done in each divide stage
    localparam int STEPS_PER_STAGE = 4;
    // number of divide stages in the pipeline
    localparam int NUM_DIV_STAGES = QUOT_BITS / STEPS_PER_STAGE;

    // largest quotient magnitudes that fit a signed word
    localparam logic [15:0] QMAX_POS = 16'h7FFF;
    localparam logic [15:0] QMAX_NEG = 16'h8000;

    // which condition flags a result updates
    typedef enum logic [1:0] {
        FU_NONE = 2'd0,
        FU_VC   = 2'd1,
        FU_NZVC = 2'd2
    } flag_upd_t;

    // divide kind
    localparam logic KIND_UNSIGNED = 1'b0;
    localparam logic KIND_SIGNED   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } wdv_in_t;

    typedef struct packed {
        logic [31:0] new_value;
        logic        write_back;
        flag_upd_t   flag_update;
        logic        neg_flag;
        logic        zero_flag;
        logic        overflow_flag;
        logic        carry_flag;
        logic        divide_by_zero;
    } wdv_out_t;

    // work state carried between divide stages
    typedef struct packed {
        logic        is_signed;
        logic        dvd_neg;
        logic        q_neg;
        logic        dz;
        logic        ovf;
        logic [15:0] ub;
        logic [15:0] rem;
        logic [15:0] low;
    } wdv_work_t;

endpackage

// ===== src/wdv_prep.sv =====
// wdv_prep: operand magnitudes, early overflow check and first stage register
`timescale 1ns / 1ps

module wdv_prep
    import wdv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  wdv_in_t   up_data,
    output logic      up_ready,
    output logic      dn_valid,
    output wdv_work_t dn_data,
    input  logic      dn_ready
);

    logic      valid_reg;
    wdv_work_t data_reg;
    wdv_work_t data_next;
    logic      take;
    logic [31:0] ua;

    assign take = !valid_reg || dn_ready;

    always_comb
    begin
        data_next.is_signed = (up_data.kind == KIND_SIGNED);
        data_next.dvd_neg   = data_next.is_signed && up_data.dividend[31];
        data_next.q_neg     = data_next.dvd_neg ^ (data_next.is_signed && up_data.divisor[15]);
        data_next.dz        = (up_data.divisor == 16'd0);
        ua                  = data_next.dvd_neg ? (32'd0 - up_data.dividend) : up_data.dividend;
        data_next.ub        = (data_next.is_signed && up_data.divisor[15])
                            ? (16'd0 - up_data.divisor) : up_data.divisor;
        // quotient needs more than 16 bits when the high half is not below the divisor
        data_next.ovf       = (ua[31:16] >= data_next.ub);
        data_next.rem       = ua[31:16];
        data_next.low       = ua[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign up_ready = take;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== src/wdv_div_stage.sv =====
// wdv_div_stage: a group of restoring divide steps with its stage register
`timescale 1ns / 1ps

module wdv_div_stage
    import wdv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  wdv_work_t up_data,
    output logic      up_ready,
    output logic      dn_valid,
    output wdv_work_t dn_data,
    input  logic      dn_ready
);

    logic      valid_reg;
    wdv_work_t data_reg;
    wdv_work_t data_next;
    logic      take;
    logic [16:0] trial;
    logic        fits;

    assign take = !valid_reg || dn_ready;

    // shift one dividend bit into the partial remainder, subtract when it fits
    always_comb
    begin
        data_next = up_data;
        trial     = 17'd0;
        fits      = 1'b0;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            trial = {data_next.rem, data_next.low[15]};
            fits  = (trial >= {1'b0, data_next.ub});
            if (fits)
            begin
                trial = trial - {1'b0, data_next.ub};
            end
            data_next.rem = trial[15:0];
            data_next.low = {data_next.low[14:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign up_ready = take;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== src/wdv_post.sv =====
// wdv_post: sign fixup, overflow limit, flags and output register
`timescale 1ns / 1ps

module wdv_post
    import wdv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  wdv_work_t up_data,
    output logic      up_ready,
    output logic      rsp_valid,
    output wdv_out_t  rsp,
    input  logic      rsp_stall
);

    logic     valid_reg;
    wdv_out_t data_reg;
    wdv_out_t data_next;
    logic     take;
    logic     sig_ovf;
    logic     ovf;
    logic [15:0] qword;
    logic [15:0] rword;

    assign take = !valid_reg || !rsp_stall;

    always_comb
    begin
        sig_ovf = up_data.is_signed
                && (up_data.q_neg ? (up_data.low > QMAX_NEG) : (up_data.low > QMAX_POS));
        ovf     = up_data.ovf || sig_ovf;
        qword   = up_data.q_neg ? (16'd0 - up_data.low) : up_data.low;
        rword   = up_data.dvd_neg ? (16'd0 - up_data.rem) : up_data.rem;

        data_next = '0;
        if (up_data.dz)
        begin
            data_next.divide_by_zero = 1'b1;
            data_next.flag_update    = FU_NONE;
        end
        else if (ovf)
        begin
            data_next.flag_update   = FU_VC;
            data_next.overflow_flag = 1'b1;
        end
        else
        begin
            data_next.new_value   = {rword, qword};
            data_next.write_back  = 1'b1;
            data_next.flag_update = FU_NZVC;
            data_next.neg_flag    = up_data.is_signed
                                  ? (up_data.q_neg && (up_data.low != 16'd0))
                                  : up_data.low[15];
            data_next.zero_flag   = (up_data.low == 16'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign up_ready  = take;
    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

// ===== src/word_divider_unsigned_signed_top.sv =====
// word_divider_unsigned_signed_top: pipelined 32-by-16 unsigned and signed divider
//
//   channel  direction  handshake             payload
//   req      into block req_valid / req_stall wdv_in_t  (kind, dividend, divisor)
//   rsp      out        rsp_valid / rsp_stall wdv_out_t (packed result and flags)
//
// one item enters per cycle unless a stall on rsp has filled every stage; a result shows on rsp
// once its item has passed the prep, divide and output registers, six register stages in all
// the divide is 16 restoring steps, 4 per divide stage, between the prep and output stages
// rst_n clears every stage valid bit at once; payload registers are not reset
// a stall on rsp holds the output; the item moves up into any empty stage ahead of it,
// so req_stall rises only when every stage holds an item
`timescale 1ns / 1ps

module word_divider_unsigned_signed_top
    import wdv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  wdv_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output wdv_out_t rsp
);

    // stage links: index 0 is the prep output, index NUM_DIV_STAGES the last divide stage
    logic      link_valid [NUM_DIV_STAGES+1];
    wdv_work_t link_data  [NUM_DIV_STAGES+1];
    logic      link_ready [NUM_DIV_STAGES+1];
    logic      req_ready;

    // magnitudes, signs and the early overflow check
    wdv_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_data  (req),
        .up_ready (req_ready),
        .dn_valid (link_valid[0]),
        .dn_data  (link_data[0]),
        .dn_ready (link_ready[0])
    );

    // restoring divide, four quotient bits per stage
    for (genvar s = 0; s < NUM_DIV_STAGES; s++)
    begin : g_div
        wdv_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[s]),
            .up_data  (link_data[s]),
            .up_ready (link_ready[s]),
            .dn_valid (link_valid[s+1]),
            .dn_data  (link_data[s+1]),
            .dn_ready (link_ready[s+1])
        );
    end

    // sign fixup, flags and the output register
    wdv_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (link_valid[NUM_DIV_STAGES]),
        .up_data   (link_data[NUM_DIV_STAGES]),
        .up_ready  (link_ready[NUM_DIV_STAGES]),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rsp_stall (rsp_stall)
    );

    assign req_stall = !req_ready;

endmodule

// ===== src/wdv_checker.sv =====
// wdv_checker: port-level assertions for the word divider, bound to the top level
`timescale 1ns / 1ps

module wdv_checker
    import wdv_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input wdv_in_t  req,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input wdv_out_t rsp
);

    // a stalled item on the input holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("stalled input item changed");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // with the output empty the pipeline always has room
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("input stalled with empty output");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("result present after reset");

    // a written result updates all four flags and reports no fault
    a_write_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.write_back |-> rsp.flag_update == FU_NZVC
            && !rsp.overflow_flag && !rsp.divide_by_zero && !rsp.carry_flag)
        else $error("write back with inconsistent flags");

endmodule

bind word_divider_unsigned_signed_top wdv_checker u_wdv_checker (.*);
